// ===== sv/trie_pkg.sv =====
// Shared types and constants for the trie word insert and lookup block.
package trie_pkg;
	localparam logic [7:0] FIRST_LETTER = 8'd97;
	localparam logic FUNC_INSERT = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;
	localparam logic [1:0] STATUS_OK = 2'd0;
	localparam logic [1:0] STATUS_BAD_CHAR = 2'd1;
	localparam logic [1:0] STATUS_POOL_FULL = 2'd2;

	typedef struct packed {
		logic       func;
		logic [7:0] char_code;
		logic       is_last;
		logic       is_empty;
	} in_word_t;

	typedef struct packed {
		logic       word_found;
		logic       prefix_found;
		logic [1:0] status;
	} out_word_t;

	// controller to datapath
	typedef struct packed {
		logic clear_step;   // run one clearing step
		logic capture;      // latch input word
		logic walk;         // apply walk result
	} trie_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clear_done;
	} trie_stat_t;
endpackage

// ===== sv/trie_ram.sv =====
// Generic single-port-write, registered-read RAM.
module trie_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ===== sv/trie_dp.sv =====
// Datapath of the trie: node memories, cursor, allocator and result forming.
module trie_dp #(
	parameter int MAX_NODES = 1024,
	parameter int ALPHABET_SIZE = 26
) (
	input  logic                clk,
	input  logic                arst_n,
	input  trie_pkg::in_word_t  in_word,
	input  trie_pkg::trie_cmd_t cmd,
	output trie_pkg::trie_stat_t stat,
	output logic                done,
	output trie_pkg::out_word_t result
);
	localparam int NW = $clog2(MAX_NODES);
	localparam int LW = $clog2(ALPHABET_SIZE);
	localparam int CW = $clog2(MAX_NODES * ALPHABET_SIZE);
	localparam int PW = ALPHABET_SIZE + 1;

	trie_pkg::in_word_t w_q;
	logic [NW-1:0] cursor_q;
	logic [NW:0]   used_q;
	logic          missing_q;
	logic [1:0]    err_q;
	logic [NW-1:0] clr_q;

	// node record: {word_end, present bits}
	logic          nd_we;
	logic [NW-1:0] nd_waddr, nd_raddr;
	logic [PW-1:0] nd_wdata, nd_rdata;
	logic          ch_we;
	logic [CW-1:0] ch_waddr, ch_raddr;
	logic [NW-1:0] ch_rdata;

	logic [7:0]          diff;
	logic                bad;
	logic [LW-1:0]       letter;
	logic [ALPHABET_SIZE-1:0] bit_m;
	logic                has_child, is_end, full;
	logic [CW-1:0]       cidx;

	assign diff = w_q.char_code - trie_pkg::FIRST_LETTER;
	assign bad = (w_q.char_code < trie_pkg::FIRST_LETTER) || (32'(diff) >= ALPHABET_SIZE);
	assign letter = diff[LW-1:0];
	assign bit_m = (ALPHABET_SIZE)'(1) << letter;
	assign has_child = |(nd_rdata[ALPHABET_SIZE-1:0] & bit_m);
	assign full = 32'(used_q) >= MAX_NODES;
	assign cidx = CW'(32'(cursor_q) * ALPHABET_SIZE + 32'(letter));
	assign stat.clear_done = 32'(clr_q) == MAX_NODES - 1;

	// character step evaluation for this item, and the end-of-word flag
	logic [NW-1:0] nxt_cursor;
	logic          nxt_missing;
	logic [1:0]    nxt_err;
	logic          alloc_ok;
	logic          ends;

	always_comb begin
		nxt_cursor = cursor_q;
		nxt_missing = missing_q;
		nxt_err = err_q;
		alloc_ok = 1'b0;
		if (!w_q.is_empty && err_q == trie_pkg::STATUS_OK && !missing_q) begin
			if (bad) begin
				nxt_err = trie_pkg::STATUS_BAD_CHAR;
			end else if (has_child) begin
				nxt_cursor = ch_rdata;
			end else if (w_q.func == trie_pkg::FUNC_QUERY) begin
				nxt_missing = 1'b1;
			end else if (full) begin
				nxt_err = trie_pkg::STATUS_POOL_FULL;
			end else begin
				alloc_ok = 1'b1;
				nxt_cursor = used_q[NW-1:0];
			end
		end
	end
	assign ends = w_q.is_last || w_q.is_empty;
	assign is_end = nd_rdata[ALPHABET_SIZE];

	// the end-of-word record for a new node is all zero; for an existing one it is
	// read again in the finish phase
	logic fin_q;
	logic fin_wr_q;
	logic [NW-1:0] fin_node_q;
	logic fin_fresh_q, fin_ok_q, fin_query_q;
	logic [1:0] fin_err_q;

	always_comb begin
		nd_we = 1'b0;
		nd_waddr = cursor_q;
		nd_wdata = nd_rdata;
		ch_we = 1'b0;
		ch_waddr = cidx;
		nd_raddr = cursor_q;
		ch_raddr = cidx;
		if (cmd.clear_step) begin
			nd_we = 1'b1;
			nd_waddr = clr_q;
			nd_wdata = '0;
		end else if (cmd.walk && alloc_ok) begin
			nd_we = 1'b1;
			nd_wdata = nd_rdata | PW'(bit_m);
			ch_we = 1'b1;
		end else if (fin_wr_q && !fin_query_q && fin_ok_q) begin
			nd_we = 1'b1;
			nd_waddr = fin_node_q;
			nd_wdata = fin_fresh_q ? PW'(1) << ALPHABET_SIZE
			                       : nd_rdata | (PW'(1) << ALPHABET_SIZE);
		end
		if (fin_q) begin
			nd_raddr = fin_node_q;
		end
	end

	trie_ram #(.WIDTH(PW), .DEPTH(MAX_NODES)) u_node (
		.clk(clk), .we(nd_we), .waddr(nd_waddr), .wdata(nd_wdata),
		.raddr(nd_raddr), .rdata(nd_rdata)
	);
	trie_ram #(.WIDTH(NW), .DEPTH(MAX_NODES * ALPHABET_SIZE)) u_child (
		.clk(clk), .we(ch_we), .waddr(ch_waddr), .wdata(used_q[NW-1:0]),
		.raddr(ch_raddr), .rdata(ch_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q <= '0;
			used_q <= (NW+1)'(1);
			missing_q <= 1'b0;
			err_q <= trie_pkg::STATUS_OK;
			clr_q <= '0;
			fin_q <= 1'b0;
			fin_wr_q <= 1'b0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			fin_q <= 1'b0;
			fin_wr_q <= fin_q;
			if (cmd.clear_step && !stat.clear_done) begin
				clr_q <= clr_q + NW'(1);
			end
			if (cmd.walk) begin
				if (alloc_ok) begin
					used_q <= used_q + (NW+1)'(1);
				end
				if (ends) begin
					fin_q <= 1'b1;
					cursor_q <= '0;
					missing_q <= 1'b0;
					err_q <= trie_pkg::STATUS_OK;
				end else begin
					cursor_q <= nxt_cursor;
					missing_q <= nxt_missing;
					err_q <= nxt_err;
				end
			end
			if (fin_wr_q) begin
				done <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			w_q <= in_word;
		end
		if (cmd.walk) begin
			fin_node_q <= nxt_cursor;
			fin_fresh_q <= alloc_ok;
			fin_ok_q <= nxt_err == trie_pkg::STATUS_OK && !nxt_missing;
			fin_query_q <= w_q.func == trie_pkg::FUNC_QUERY;
			fin_err_q <= nxt_err;
		end
		if (fin_wr_q) begin
			result.word_found <= fin_query_q && fin_ok_q && !fin_fresh_q && is_end;
			result.prefix_found <= fin_query_q && fin_ok_q;
			result.status <= fin_err_q;
		end
	end
endmodule

// ===== sv/trie_ctrl.sv =====
// Controller state machine of the trie: clearing pass, capture, lookup, walk.
module trie_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  trie_pkg::trie_stat_t stat,
	input  logic                 fin_busy,
	output logic                 busy,
	output trie_pkg::trie_cmd_t  cmd
);
	typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_READ, ST_WALK} state_t;
	state_t state_q;

	always_comb begin
		cmd = '0;
		cmd.clear_step = state_q == ST_CLEAR;
		cmd.capture = state_q == ST_IDLE && start && !fin_busy;
		cmd.walk = state_q == ST_WALK;
		busy = state_q != ST_IDLE || fin_busy;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			unique case (state_q)
				ST_CLEAR: if (stat.clear_done) state_q <= ST_IDLE;
				ST_IDLE:  if (start && !fin_busy) state_q <= ST_READ;
				ST_READ:  state_q <= ST_WALK;
				ST_WALK:  state_q <= ST_IDLE;
				default:  state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// ===== sv/trie_word_insert_and_lookup.sv =====
// Top level of the trie word insert and lookup block.
// Usage:
//  Drive in_word with start; the word is taken at an edge where start is high
//  and busy is low. Words carry one character; is_last or is_empty ends a word.
//  func chooses insert or query per word.
//  A word that ends a trie word yields one result on out_word, marked by
//  out_valid for one cycle; out_valid rises after the READ and WALK states
//  and the finish registers fin_q, fin_wr_q and done. Other words yield no result.
//  Each character passes the accept, read and walk states before the next is
//  taken; an ending word also holds busy while the final node's record is
//  read for the end-mark read-modify-write in the node memory.
//  After reset, a clearing pass zeroes all MAX_NODES node records;
//  busy stays high during it.
//  The receiver cannot stall; each result is shown for one cycle only.
module trie_word_insert_and_lookup #(
	parameter int MAX_NODES = 1024,
	parameter int ALPHABET_SIZE = 26
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  trie_pkg::in_word_t  in_word,
	output logic                busy,
	output logic                out_valid,
	output trie_pkg::out_word_t out_word
);
	trie_pkg::trie_cmd_t  cmd;
	trie_pkg::trie_stat_t stat;
	logic fin_busy_q;
	logic in_word_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fin_busy_q <= 1'b0;
		end else begin
			fin_busy_q <= cmd.walk && (in_word_last_q);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			in_word_last_q <= in_word.is_last || in_word.is_empty;
		end
	end

	trie_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .stat(stat),
		.fin_busy(fin_busy_q), .busy(busy), .cmd(cmd)
	);

	trie_dp #(.MAX_NODES(MAX_NODES), .ALPHABET_SIZE(ALPHABET_SIZE)) u_dp (
		.clk(clk), .arst_n(arst_n), .in_word(in_word), .cmd(cmd), .stat(stat),
		.done(out_valid), .result(out_word)
	);
endmodule

// ===== sim/trie_word_insert_and_lookup_tb.sv =====
// Self-checking testbench for the trie word insert and lookup block.
`timescale 1ns / 1ps

module trie_word_insert_and_lookup_tb;
	localparam int MAX_NODES = 1024;
	localparam int ALPHABET_SIZE = 26;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	trie_pkg::in_word_t in_word = '0;
	logic busy;
	logic out_valid;
	trie_pkg::out_word_t out_word;

	trie_word_insert_and_lookup #(
		.MAX_NODES(MAX_NODES),
		.ALPHABET_SIZE(ALPHABET_SIZE)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.in_word(in_word),
		.busy(busy),
		.out_valid(out_valid),
		.out_word(out_word)
	);

	always #5 clk = ~clk;

	// Trie shadow state
	logic [9:0] tr_child [MAX_NODES*ALPHABET_SIZE];
	logic [ALPHABET_SIZE-1:0] tr_present [MAX_NODES];
	logic tr_end [MAX_NODES];
	int unsigned tr_used;
	int unsigned tr_cursor;
	logic tr_missing;
	logic [1:0] tr_err;

	trie_pkg::in_word_t pending_words[$];
	trie_pkg::out_word_t expected_lookups[$];
	int errors = 0;
	int results_seen = 0;
	int words_sent = 0;
	bit stim_done = 0;
	bit quiet_send = 0;
	bit hold_send = 0;

	task automatic trie_reset();
		for (int i = 0; i < MAX_NODES; i++) begin
			tr_present[i] = '0;
			tr_end[i] = 1'b0;
		end
		tr_used = 1;
		tr_cursor = 0;
		tr_missing = 1'b0;
		tr_err = trie_pkg::STATUS_OK;
	endtask

	task automatic trie_apply(input trie_pkg::in_word_t w);
		int unsigned letter;
		trie_pkg::out_word_t r;
		if (!w.is_empty && tr_err == trie_pkg::STATUS_OK && !tr_missing) begin
			if (w.char_code < trie_pkg::FIRST_LETTER ||
					32'(w.char_code) - 32'(trie_pkg::FIRST_LETTER) >= ALPHABET_SIZE) begin
				tr_err = trie_pkg::STATUS_BAD_CHAR;
			end else begin
				letter = 32'(w.char_code) - 32'(trie_pkg::FIRST_LETTER);
				if (tr_present[tr_cursor][letter]) begin
					tr_cursor = 32'(tr_child[tr_cursor*ALPHABET_SIZE + letter]);
				end else if (w.func == trie_pkg::FUNC_QUERY) begin
					tr_missing = 1'b1;
				end else if (tr_used >= MAX_NODES) begin
					tr_err = trie_pkg::STATUS_POOL_FULL;
				end else begin
					tr_present[tr_used] = '0;
					tr_end[tr_used] = 1'b0;
					tr_child[tr_cursor*ALPHABET_SIZE + letter] = 10'(tr_used);
					tr_present[tr_cursor][letter] = 1'b1;
					tr_cursor = tr_used;
					tr_used++;
				end
			end
		end
		if (w.is_last || w.is_empty) begin
			r = '0;
			if (tr_err == trie_pkg::STATUS_OK && !tr_missing) begin
				if (w.func == trie_pkg::FUNC_QUERY) begin
					r.prefix_found = 1'b1;
					r.word_found = tr_end[tr_cursor];
				end else begin
					tr_end[tr_cursor] = 1'b1;
				end
			end
			r.status = tr_err;
			expected_lookups.push_back(r);
			tr_cursor = 0;
			tr_missing = 1'b0;
			tr_err = trie_pkg::STATUS_OK;
		end
	endtask

	function automatic trie_pkg::in_word_t mk(logic f, logic [7:0] c, logic l, logic e);
		trie_pkg::in_word_t w;
		w.func = f;
		w.char_code = c;
		w.is_last = l;
		w.is_empty = e;
		return w;
	endfunction

	task automatic add_word(input logic f, input string s);
		for (int i = 0; i < s.len(); i++)
			pending_words.push_back(mk(f, s[i], i == s.len() - 1, 1'b0));
	endtask

	task automatic add_random_word(input int maxlen, input int alpha);
		int n;
		logic f;
		logic [7:0] c;
		n = $urandom_range(1, maxlen);
		f = 1'($urandom_range(0, 1));
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 99) < 3)
				c = 8'($urandom_range(0, 255));
			else
				c = 8'(trie_pkg::FIRST_LETTER + $urandom_range(0, alpha - 1));
			pending_words.push_back(mk($urandom_range(0, 19) == 0 ? ~f : f, c,
				i == n - 1, 1'b0));
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && start && !busy) begin
			trie_apply(in_word);
			words_sent++;
		end
		if (arst_n && (!start || !busy)) begin
			if (pending_words.size() != 0 && !hold_send &&
					(quiet_send || $urandom_range(0, 99) >= 18)) begin
				start <= 1'b1;
				in_word <= pending_words.pop_front();
			end else begin
				start <= 1'b0;
				in_word <= {1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
					1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))};
			end
		end
	end

	always @(posedge clk) begin
		trie_pkg::out_word_t exp_r;
		if (arst_n && out_valid) begin
			results_seen++;
			if (expected_lookups.size() == 0) begin
				$error("result with nothing expected: %b", out_word);
				errors++;
			end else begin
				exp_r = expected_lookups.pop_front();
				if (out_word.word_found !== exp_r.word_found) begin
					$error("word_found expected %0d actual %0d", exp_r.word_found,
						out_word.word_found);
					errors++;
				end
				if (out_word.prefix_found !== exp_r.prefix_found) begin
					$error("prefix_found expected %0d actual %0d", exp_r.prefix_found,
						out_word.prefix_found);
					errors++;
				end
				if (out_word.status !== exp_r.status) begin
					$error("status expected %0d actual %0d", exp_r.status, out_word.status);
					errors++;
				end
			end
		end
	end

	initial begin
		trie_reset();
		add_word(trie_pkg::FUNC_QUERY, "a");
		pending_words.push_back(mk(trie_pkg::FUNC_INSERT, 8'd0, 1'b1, 1'b1));
		pending_words.push_back(mk(trie_pkg::FUNC_QUERY, 8'd0, 1'b0, 1'b1));
		add_word(trie_pkg::FUNC_INSERT, "az");
		add_word(trie_pkg::FUNC_QUERY, "az");
		add_word(trie_pkg::FUNC_QUERY, "a");
		add_word(trie_pkg::FUNC_QUERY, "ab");
		pending_words.push_back(mk(trie_pkg::FUNC_INSERT, 8'd96, 1'b1, 1'b0));
		pending_words.push_back(mk(trie_pkg::FUNC_QUERY, 8'd123, 1'b1, 1'b0));
		pending_words.push_back(mk(trie_pkg::FUNC_INSERT, 8'd255, 1'b0, 1'b0));
		pending_words.push_back(mk(trie_pkg::FUNC_INSERT, 8'd97, 1'b1, 1'b0));
		pending_words.push_back(mk(trie_pkg::FUNC_INSERT, 8'd97, 1'b0, 1'b0));
		pending_words.push_back(mk(trie_pkg::FUNC_QUERY, 8'd122, 1'b1, 1'b0));
		add_word(trie_pkg::FUNC_QUERY, "a");
		add_word(trie_pkg::FUNC_QUERY, "za");
		while (pending_words.size() < 290)
			add_random_word(5, ($urandom_range(0, 2) == 0) ? ALPHABET_SIZE : 4);
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		wait (words_sent > 120);
		hold_send = 1'b1;
		wait (expected_lookups.size() == 0);
		repeat (10) @(posedge clk);
		hold_send = 1'b0;
		quiet_send = 1'b1;
		wait (words_sent > 230);
		quiet_send = 1'b0;
		// Exhaust the node pool with long fresh inserts
		while (tr_used < MAX_NODES) begin
			for (int j = 0; j < 24; j++)
				pending_words.push_back(mk(trie_pkg::FUNC_INSERT,
					8'(trie_pkg::FIRST_LETTER + $urandom_range(0, ALPHABET_SIZE - 1)),
					j == 23, 1'b0));
			wait (pending_words.size() == 0);
		end
		for (int i = 0; i < 20; i++)
			add_random_word(4, ALPHABET_SIZE);
		add_word(trie_pkg::FUNC_QUERY, "a");
		wait (pending_words.size() == 0 && !start);
		wait (expected_lookups.size() == 0);
		repeat (20) @(posedge clk);
		$display("Sent %0d words, checked %0d results over inserts, queries,", words_sent,
			results_seen);
		$display("bad characters, empty words and node pool exhaustion.");
		if (errors == 0 && expected_lookups.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		#5ms;
		$display("DONE: errors detected");
		$finish;
	end
endmodule
